[design/chb_pkg.sv]
// ----------------------------------------------------------------------------
// chb_pkg
// Shared constants, types and helpers of the canonical Huffman block decoder.
// ----------------------------------------------------------------------------
package chb_pkg;

   localparam int SYM_BITS      = 8;
   localparam int CODE_LEN_MAX  = 16;
   localparam int COUNT_BITS    = 9;
   localparam int WORD_BITS     = 32;
   localparam int MAX_OUT       = 32;
   localparam int BLEN_BITS     = 16;
   localparam int NUM_SYMS      = 1 << SYM_BITS;
   localparam int LANES         = 8;
   localparam int ROWS          = NUM_SYMS / LANES;
   localparam int ACC_BITS      = 64;
   localparam int CNT_BITS      = 7;
   localparam int LEN_BITS      = $clog2(CODE_LEN_MAX + 2);
   localparam int LIDX_BITS     = $clog2(CODE_LEN_MAX);
   localparam int ROW_BITS      = $clog2(ROWS);
   localparam int LANE_BITS     = $clog2(LANES);
   localparam int NOUT_BITS     = $clog2(MAX_OUT + 1);

   localparam logic [BLEN_BITS-1:0] BLOCK_LEN_RESET = BLEN_BITS'(4096);

   typedef logic [WORD_BITS-1:0]    word_type;
   typedef logic [SYM_BITS-1:0]     sym_type;
   typedef logic [CODE_LEN_MAX-1:0] code_type;
   typedef logic [LEN_BITS-1:0]     len_type;
   typedef logic [BLEN_BITS-1:0]    blen_type;
   typedef logic [COUNT_BITS-1:0]   count_type;

   typedef struct packed {
      len_type  len;
      code_type code;
   } entry_type;

   typedef struct packed {
      logic load_word;
      logic take_count;
      logic start_symbols;
      logic next_length;
      logic take_symbol;
      logic enter_decode;
      logic restart_header;
      logic scan_start;
      logic emit_ok;
      logic emit_err;
      logic push_pend;
      logic push_last;
   } dp_cmd_type;

   typedef struct packed {
      logic has_count;
      logic has_symbol;
      logic has_code;
      logic left_zero;
      logic li_last;
      logic bl_zero;
      logic scan_done;
      logic no_match;
      logic block_done;
      logic n_full;
      logic pend_valid;
      logic out_free;
   } dp_status_type;

   // Bit reversal so that codes can be matched against the LSB-first stream.
   function automatic code_type mirror_code(input code_type v);
      code_type r;
      for (int i = 0; i < CODE_LEN_MAX; i++) begin
         r[CODE_LEN_MAX-1-i] = v[i];
      end
      return r;
   endfunction

endpackage

[design/chb_if.sv]
// ----------------------------------------------------------------------------
// chb_req_if / chb_rsp_if
// Valid/ready channels for stream words in and decoded symbols out.
// ----------------------------------------------------------------------------
interface chb_req_if;
   logic                valid;
   logic                ready;
   chb_pkg::word_type   enc_word;

   modport source (output valid, output enc_word, input ready);
   modport sink   (input valid, input enc_word, output ready);
endinterface

interface chb_rsp_if;
   logic                valid;
   logic                ready;
   chb_pkg::sym_type    symbol;
   logic                block_end;
   logic                decode_error;
   logic                last;

   modport source (output valid, output symbol, output block_end, output decode_error,
                   output last, input ready);
   modport sink   (input valid, input symbol, input block_end, input decode_error,
                   input last, output ready);
endinterface

[design/canonical_huffman_block_decoder.sv]
// ----------------------------------------------------------------------------
// canonical_huffman_block_decoder
// Decodes a little-endian bit stream of canonical Huffman coded blocks.
//
//   Channel  Direction  Handshake          Payload
//   req_ch   in         valid/ready        enc_word[31:0]
//   rsp_ch   out        valid/ready        symbol[7:0], block_end, decode_error, last
//   csr      in         csr_we             csr_wdata[15:0] = block_length
//
// One word is worked off completely before the next is taken.
// Header counts and header symbols are taken in the run state; each decoded
// symbol is found by a scan over the 32 rows of the code table memory
// (eight symbols per row). Reset is synchronous; code table entries need no
// clearing since per-symbol valid bits are cleared at every header. A stalled
// result output holds the scan sequencer once one further result is ready.
// ----------------------------------------------------------------------------
module canonical_huffman_block_decoder (
   input  logic              clock,
   input  logic              reset,
   chb_req_if.sink           req_ch,
   chb_rsp_if.source         rsp_ch,
   input  logic              csr_we,
   input  chb_pkg::blen_type csr_wdata
);
   import chb_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type sts;

   chb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   chb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_ch.enc_word),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ch    (rsp_ch)
   );

endmodule

[design/chb_ctrl.sv]
// ----------------------------------------------------------------------------
// chb_ctrl
// Sequencer: walks the header, the code table build and the symbol decode.
// ----------------------------------------------------------------------------
module chb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  chb_pkg::dp_status_type sts,
   output chb_pkg::dp_cmd_type    cmd
);
   import chb_pkg::*;

   localparam logic [1:0] PH_COUNTS  = 2'd0;
   localparam logic [1:0] PH_SYMBOLS = 2'd1;
   localparam logic [1:0] PH_DECODE  = 2'd2;
   localparam logic [1:0] PH_HALT    = 2'd3;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RUN   = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_MATCH = 3'd3;
   localparam logic [2:0] ST_FLUSH = 3'd4;

   logic [1:0] phase_ff, phase_in;
   logic [2:0] st_ff, st_in;

   assign req_ready = (st_ff == ST_IDLE);

   always_comb begin
      phase_in = phase_ff;
      st_in    = st_ff;
      cmd      = '0;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_valid && phase_ff != PH_HALT) begin
               cmd.load_word = 1'b1;
               st_in         = ST_RUN;
            end
         end
         ST_RUN: begin
            unique case (phase_ff)
               PH_COUNTS: begin
                  if (sts.has_count) begin
                     cmd.take_count = 1'b1;
                     if (sts.li_last) begin
                        cmd.start_symbols = 1'b1;
                        phase_in          = PH_SYMBOLS;
                     end
                  end else begin
                     st_in = ST_FLUSH;
                  end
               end
               PH_SYMBOLS: begin
                  if (sts.left_zero) begin
                     cmd.next_length = 1'b1;
                     if (sts.li_last) begin
                        cmd.enter_decode = 1'b1;
                        phase_in         = PH_DECODE;
                     end
                  end else if (sts.has_symbol) begin
                     cmd.take_symbol = 1'b1;
                  end else begin
                     st_in = ST_FLUSH;
                  end
               end
               PH_DECODE: begin
                  if (sts.bl_zero) begin
                     cmd.restart_header = 1'b1;
                     phase_in           = PH_COUNTS;
                  end else if (sts.n_full || !sts.has_code) begin
                     st_in = ST_FLUSH;
                  end else begin
                     cmd.scan_start = 1'b1;
                     st_in          = ST_SCAN;
                  end
               end
               default: st_in = ST_FLUSH;
            endcase
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               st_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            // The previous result leaves only once we know it is not the last one.
            if (!sts.pend_valid || sts.out_free) begin
               cmd.push_pend = sts.pend_valid;
               if (sts.no_match) begin
                  cmd.emit_err = 1'b1;
                  phase_in     = PH_HALT;
                  st_in        = ST_FLUSH;
               end else begin
                  cmd.emit_ok = 1'b1;
                  if (sts.block_done) begin
                     cmd.restart_header = 1'b1;
                     phase_in           = PH_COUNTS;
                  end
                  st_in = ST_RUN;
               end
            end
         end
         ST_FLUSH: begin
            if (!sts.pend_valid) begin
               st_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.push_pend = 1'b1;
               cmd.push_last = 1'b1;
               st_in         = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COUNTS;
         st_ff    <= ST_IDLE;
      end else begin
         phase_ff <= phase_in;
         st_ff    <= st_in;
      end
   end

endmodule

[design/chb_dp.sv]
// ----------------------------------------------------------------------------
// chb_dp
// Datapath: bit accumulator, header registers, code table memory with a
// row-at-a-time match scan, result holding register and output register.
// ----------------------------------------------------------------------------
module chb_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  chb_pkg::word_type      req_word,
   input  logic                   csr_we,
   input  chb_pkg::blen_type      csr_wdata,
   input  chb_pkg::dp_cmd_type    cmd,
   output chb_pkg::dp_status_type sts,
   chb_rsp_if.source              rsp_ch
);
   import chb_pkg::*;

   logic [ACC_BITS-1:0]  acc_ff, acc_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]  take_w;
   blen_type             blen_ff;
   count_type            counts_ff [CODE_LEN_MAX];
   len_type              li_ff;
   count_type            left_ff;
   code_type             next_code_ff;
   blen_type             decoded_ff;
   logic [NOUT_BITS-1:0] n_ff;
   logic [NUM_SYMS-1:0]  vld_ff;

   entry_type            code_mem [ROWS][LANES];
   entry_type            rd_row_ff [LANES];
   logic [LANES-1:0]     rd_vld_ff;
   logic                 rd_v_ff;
   logic [ROW_BITS-1:0]  rd_idx_ff;
   logic [ROW_BITS-1:0]  row_ff;
   logic                 scan_active_ff;
   len_type              best_len_ff;
   sym_type              best_sym_ff;
   len_type              cand_len;
   sym_type              cand_sym;

   logic                 pend_v_ff;
   sym_type              pend_sym_ff;
   logic                 pend_end_ff;
   logic                 pend_err_ff;
   logic                 rsp_v_ff;
   sym_type              rsp_sym_ff;
   logic                 rsp_end_ff;
   logic                 rsp_err_ff;
   logic                 rsp_last_ff;

   sym_type              wr_sym;
   code_type             acc_code;
   logic                 block_done;

   assign wr_sym     = acc_ff[SYM_BITS-1:0];
   assign acc_code   = acc_ff[CODE_LEN_MAX-1:0];
   assign block_done = ({1'b0, decoded_ff} + (BLEN_BITS+1)'(1)) >= {1'b0, blen_ff};

   always_comb begin
      if (cmd.take_count) begin
         take_w = CNT_BITS'(COUNT_BITS);
      end else if (cmd.take_symbol) begin
         take_w = CNT_BITS'(SYM_BITS);
      end else if (cmd.emit_ok) begin
         take_w = CNT_BITS'(best_len_ff);
      end else begin
         take_w = '0;
      end
      if (cmd.load_word) begin
         acc_in = acc_ff | (ACC_BITS'(req_word) << cnt_ff);
         cnt_in = cnt_ff + CNT_BITS'(WORD_BITS);
      end else begin
         acc_in = acc_ff >> take_w;
         cnt_in = cnt_ff - take_w;
      end
   end

   // Best match within one table row: shortest code, then lowest symbol.
   always_comb begin
      code_type mask;
      cand_len = '0;
      cand_sym = '0;
      for (int l = 0; l < LANES; l++) begin
         mask = ~(code_type'('1) << rd_row_ff[l].len);
         if (rd_vld_ff[l] && ((acc_code & mask) == rd_row_ff[l].code)
             && (cand_len == '0 || rd_row_ff[l].len < cand_len)) begin
            cand_len = rd_row_ff[l].len;
            cand_sym = {rd_idx_ff, LANE_BITS'(l)};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_symbol) begin
         code_mem[wr_sym[SYM_BITS-1:LANE_BITS]][wr_sym[LANE_BITS-1:0]] <=
            '{len: li_ff, code: mirror_code(next_code_ff)};
      end
      if (scan_active_ff) begin
         rd_row_ff <= code_mem[row_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff         <= '0;
         cnt_ff         <= '0;
         blen_ff        <= BLOCK_LEN_RESET;
         for (int i = 0; i < CODE_LEN_MAX; i++) begin
            counts_ff[i] <= '0;
         end
         li_ff          <= LEN_BITS'(1);
         left_ff        <= '0;
         next_code_ff   <= '0;
         decoded_ff     <= '0;
         n_ff           <= '0;
         vld_ff         <= '0;
         rd_vld_ff      <= '0;
         rd_v_ff        <= 1'b0;
         rd_idx_ff      <= '0;
         row_ff         <= '0;
         scan_active_ff <= 1'b0;
         best_len_ff    <= '0;
         best_sym_ff    <= '0;
         pend_v_ff      <= 1'b0;
         rsp_v_ff       <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         if (csr_we) begin
            blen_ff <= csr_wdata;
         end
         if (cmd.load_word) begin
            n_ff <= '0;
         end
         if (cmd.take_count) begin
            counts_ff[LIDX_BITS'(li_ff - LEN_BITS'(1))] <= acc_ff[COUNT_BITS-1:0];
         end
         if (cmd.start_symbols || cmd.restart_header) begin
            li_ff <= LEN_BITS'(1);
         end else if (cmd.take_count || cmd.next_length) begin
            li_ff <= li_ff + LEN_BITS'(1);
         end
         if (cmd.start_symbols) begin
            left_ff      <= counts_ff[0];
            next_code_ff <= '0;
            vld_ff       <= '0;
         end
         if (cmd.next_length) begin
            if (li_ff != LEN_BITS'(CODE_LEN_MAX)) begin
               left_ff <= counts_ff[LIDX_BITS'(li_ff)];
            end
         end
         if (cmd.take_symbol) begin
            vld_ff[wr_sym] <= 1'b1;
            next_code_ff   <= next_code_ff
                              + (code_type'(1) << (LEN_BITS'(CODE_LEN_MAX) - li_ff));
            left_ff        <= left_ff - COUNT_BITS'(1);
         end
         if (cmd.enter_decode) begin
            decoded_ff <= '0;
         end

         // Row scan: read one row per cycle, compare it the cycle after.
         if (cmd.scan_start) begin
            row_ff         <= '0;
            scan_active_ff <= 1'b1;
            best_len_ff    <= '0;
         end else if (scan_active_ff) begin
            row_ff <= row_ff + ROW_BITS'(1);
            if (row_ff == ROW_BITS'(ROWS - 1)) begin
               scan_active_ff <= 1'b0;
            end
         end
         rd_v_ff <= scan_active_ff;
         if (scan_active_ff) begin
            rd_idx_ff <= row_ff;
            rd_vld_ff <= vld_ff[{row_ff, {LANE_BITS{1'b0}}} +: LANES];
         end
         if (rd_v_ff && cand_len != '0 && (best_len_ff == '0 || cand_len < best_len_ff)) begin
            best_len_ff <= cand_len;
            best_sym_ff <= cand_sym;
         end

         if (cmd.emit_ok || cmd.emit_err) begin
            pend_v_ff <= 1'b1;
         end else if (cmd.push_pend) begin
            pend_v_ff <= 1'b0;
         end
         if (cmd.emit_ok) begin
            pend_sym_ff <= best_sym_ff;
            pend_end_ff <= block_done;
            pend_err_ff <= 1'b0;
            n_ff        <= n_ff + NOUT_BITS'(1);
            decoded_ff  <= block_done ? '0 : decoded_ff + BLEN_BITS'(1);
         end
         if (cmd.emit_err) begin
            pend_sym_ff <= '0;
            pend_end_ff <= 1'b0;
            pend_err_ff <= 1'b1;
            n_ff        <= n_ff + NOUT_BITS'(1);
         end

         if (cmd.push_pend) begin
            rsp_v_ff    <= 1'b1;
            rsp_sym_ff  <= pend_sym_ff;
            rsp_end_ff  <= pend_end_ff;
            rsp_err_ff  <= pend_err_ff;
            rsp_last_ff <= cmd.push_last;
         end else if (rsp_ch.ready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid        = rsp_v_ff;
   assign rsp_ch.symbol       = rsp_sym_ff;
   assign rsp_ch.block_end    = rsp_end_ff;
   assign rsp_ch.decode_error = rsp_err_ff;
   assign rsp_ch.last         = rsp_last_ff;

   assign sts.has_count  = cnt_ff >= CNT_BITS'(COUNT_BITS);
   assign sts.has_symbol = cnt_ff >= CNT_BITS'(SYM_BITS);
   assign sts.has_code   = cnt_ff >= CNT_BITS'(CODE_LEN_MAX);
   assign sts.left_zero  = (left_ff == '0);
   assign sts.li_last    = (li_ff == LEN_BITS'(CODE_LEN_MAX));
   assign sts.bl_zero    = (blen_ff == '0);
   assign sts.scan_done  = rd_v_ff && (rd_idx_ff == ROW_BITS'(ROWS - 1));
   assign sts.no_match   = (best_len_ff == '0);
   assign sts.block_done = block_done;
   assign sts.n_full     = n_ff >= NOUT_BITS'(MAX_OUT);
   assign sts.pend_valid = pend_v_ff;
   assign sts.out_free   = !rsp_v_ff || rsp_ch.ready;

endmodule

[design/chb_checker.sv]
// ----------------------------------------------------------------------------
// chb_checker
// Port-level checks of the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module chb_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input chb_pkg::sym_type rsp_symbol,
   input logic             rsp_block_end,
   input logic             rsp_decode_error,
   input logic             rsp_last
);
   import chb_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol)
         && $stable(rsp_block_end) && $stable(rsp_decode_error) && $stable(rsp_last))
      else $error("result word changed while stalled");

   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_decode_error |-> rsp_last && !rsp_block_end && rsp_symbol == '0)
      else $error("error word is malformed");

   a_err_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_decode_error |=> !rsp_valid)
      else $error("result word after decode error");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word right after reset");

endmodule

bind canonical_huffman_block_decoder chb_checker u_chb_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_symbol       (rsp_ch.symbol),
   .rsp_block_end    (rsp_ch.block_end),
   .rsp_decode_error (rsp_ch.decode_error),
   .rsp_last         (rsp_ch.last)
);

[tb/tb_canonical_huffman_block_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_canonical_huffman_block_decoder
// Builds canonical code books and encodes blocks of symbols against them. The
// bit stream goes in 32-bit words over the request channel. A cycle-free model
// of the decoder predicts every decoded word, and each one on the response
// channel is checked against it field by field. The stream covers complete,
// incomplete, oversubscribed and duplicate books, the longest codes, a block
// length change in mid-block, and the halt after a failed match.
// ----------------------------------------------------------------------------
module tb_canonical_huffman_block_decoder;
   import chb_pkg::*;

   localparam int SETTLE_CYCLES = 1500;
   localparam int QUIET_LIMIT   = 20000;

   typedef enum logic [1:0] {HDR_COUNTS, HDR_SYMBOLS, SYM_DECODE, HALTED} stage_type;

   typedef struct packed {
      sym_type symbol;
      logic    block_end;
      logic    decode_error;
      logic    last;
   } decoded_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   blen_type csr_wdata = '0;

   chb_req_if req_ch ();
   chb_rsp_if rsp_ch ();

   canonical_huffman_block_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Decoder state as the predictor sees it.
   logic [63:0]    acc_bits;
   int             acc_count;
   stage_type      stage;
   int             len_idx;
   int             len_counts [CODE_LEN_MAX+1];
   int             left_at_len;
   code_type       code_next;
   int             sym_len [NUM_SYMS];
   code_type       sym_mirror [NUM_SYMS];
   int             decoded_in_block;
   int             blk_length;

   decoded_type    decoded_q [$];
   word_type       enc_word_q [$];
   bit             stream_bits [$];
   int             book_sym [$];
   int             book_len [$];
   code_type       book_code [$];
   int             words_made;
   int             mismatch_count;
   int             send_idle_pct;
   int             recv_idle_pct;
   int             quiet_cycles;

   function automatic int take_bits(int w);
      int v;
      v = int'(acc_bits & ((64'd1 << w) - 64'd1));
      acc_bits  = acc_bits >> w;
      acc_count -= w;
      return v;
   endfunction

   function automatic void push_decoded(int sym, bit blk_end, bit err);
      decoded_type d;
      d.symbol       = sym_type'(sym);
      d.block_end    = blk_end;
      d.decode_error = err;
      d.last         = 1'b0;
      decoded_q.insert(decoded_q.size(), d);
   endfunction

   function automatic void predict_word(word_type w);
      int n;
      int win_len;
      int win_sym;
      int s;
      int l;
      code_type code;
      n = 0;
      if (stage == HALTED) return;
      acc_bits  = acc_bits | (64'(w) << acc_count);
      acc_count += WORD_BITS;
      while (1) begin
         if (stage == HDR_COUNTS) begin
            if (acc_count < COUNT_BITS) break;
            len_counts[len_idx] = take_bits(COUNT_BITS);
            len_idx++;
            if (len_idx > CODE_LEN_MAX) begin
               stage = HDR_SYMBOLS;
               len_idx = 1;
               left_at_len = len_counts[1];
               code_next = '0;
               foreach (sym_len[i]) sym_len[i] = 0;
            end
         end else if (stage == HDR_SYMBOLS) begin
            if (left_at_len == 0) begin
               len_idx++;
               if (len_idx > CODE_LEN_MAX) begin
                  stage = SYM_DECODE;
                  decoded_in_block = 0;
               end else begin
                  left_at_len = len_counts[len_idx];
               end
               continue;
            end
            if (acc_count < SYM_BITS) break;
            s = take_bits(SYM_BITS);
            sym_len[s] = len_idx;
            sym_mirror[s] = {<<{code_next}};
            code_next = code_next + code_type'(1 << (CODE_LEN_MAX - len_idx));
            left_at_len--;
         end else if (stage == SYM_DECODE) begin
            if (blk_length == 0) begin
               stage = HDR_COUNTS;
               len_idx = 1;
               continue;
            end
            if (n >= MAX_OUT || acc_count < CODE_LEN_MAX) break;
            win_len = 0;
            win_sym = 0;
            for (s = 0; s < NUM_SYMS; s++) begin
               l = sym_len[s];
               if (l != 0 && (win_len == 0 || l < win_len)) begin
                  code = code_type'(acc_bits & ((64'd1 << l) - 64'd1));
                  if (code == sym_mirror[s]) begin
                     win_len = l;
                     win_sym = s;
                  end
               end
            end
            if (win_len == 0) begin
               push_decoded(0, 1'b0, 1'b1);
               n++;
               stage = HALTED;
               break;
            end
            void'(take_bits(win_len));
            if (decoded_in_block + 1 >= blk_length) begin
               push_decoded(win_sym, 1'b1, 1'b0);
               stage = HDR_COUNTS;
               len_idx = 1;
               decoded_in_block = 0;
            end else begin
               push_decoded(win_sym, 1'b0, 1'b0);
               decoded_in_block = (decoded_in_block + 1) & 16'hFFFF;
            end
            n++;
         end else begin
            break;
         end
      end
      if (n > 0) decoded_q[decoded_q.size()-1].last = 1'b1;
   endfunction

   // ---- Stream construction ----

   task automatic push_bits(logic [31:0] v, int width);
      for (int i = 0; i < width; i++) stream_bits.insert(stream_bits.size(), v[i]);
   endtask

   // Complete code tree: 2^base leaves at depth base, then leaf splits. A
   // chained tree always splits its deepest leaf.
   task automatic book_tree(int base, int splits, bit chain);
      int lens [$];
      int pool [NUM_SYMS];
      int idx;
      int l;
      int t;
      int cnt;
      lens = {};
      repeat (1 << base) lens.insert(lens.size(), base);
      repeat (splits) begin
         idx = chain ? lens.size() - 1 : $urandom_range(lens.size() - 1);
         if (lens[idx] < CODE_LEN_MAX && lens.size() < NUM_SYMS) begin
            l = lens[idx];
            lens.delete(idx);
            lens.insert(lens.size(), l + 1);
            lens.insert(lens.size(), l + 1);
         end
      end
      for (int i = 0; i < NUM_SYMS; i++) pool[i] = i;
      for (int i = NUM_SYMS - 1; i > 0; i--) begin
         idx = $urandom_range(i);
         t = pool[i];
         pool[i] = pool[idx];
         pool[idx] = t;
      end
      book_sym.delete();
      book_len.delete();
      cnt = 0;
      for (int len = 1; len <= CODE_LEN_MAX; len++) begin
         foreach (lens[i]) begin
            if (lens[i] == len) begin
               book_sym.insert(book_sym.size(), pool[cnt]);
               book_len.insert(book_len.size(), len);
               cnt++;
            end
         end
      end
   endtask

   // Three one-bit codes: the third wraps onto the first code. With dup set,
   // the first symbol is listed again and keeps its last code.
   task automatic book_oversubscribed(bit dup);
      int a;
      int b;
      a = $urandom_range(NUM_SYMS - 1);
      b = (a + 1 + $urandom_range(NUM_SYMS - 2)) % NUM_SYMS;
      book_sym = {a, b, dup ? a : (a + 128) % NUM_SYMS};
      book_len = {1, 1, 1};
   endtask

   task automatic put_header();
      int counts [CODE_LEN_MAX+1];
      code_type nc;
      foreach (counts[i]) counts[i] = 0;
      foreach (book_len[i]) counts[book_len[i]]++;
      for (int len = 1; len <= CODE_LEN_MAX; len++) push_bits(counts[len], COUNT_BITS);
      book_code.delete();
      nc = '0;
      foreach (book_sym[i]) begin
         push_bits(book_sym[i], SYM_BITS);
         book_code.insert(book_code.size(), nc);
         nc = nc + code_type'(1 << (CODE_LEN_MAX - book_len[i]));
      end
   endtask

   // Codes go out MSB first, which matches the mirrored LSB-first lookup.
   task automatic emit_symbols(int count, int pick);
      int idx;
      repeat (count) begin
         idx = (pick >= 0) ? pick : $urandom_range(book_sym.size() - 1);
         for (int j = 0; j < book_len[idx]; j++)
            stream_bits.insert(stream_bits.size(), book_code[idx][CODE_LEN_MAX-1-j]);
      end
   endtask

   task automatic flush_words();
      word_type w;
      while (stream_bits.size() >= WORD_BITS) begin
         for (int i = 0; i < WORD_BITS; i++) w[i] = stream_bits.pop_front();
         enc_word_q.insert(enc_word_q.size(), w);
         words_made++;
      end
   endtask

   task automatic pad_words();
      while (stream_bits.size() % WORD_BITS != 0)
         stream_bits.insert(stream_bits.size(), 1'b0);
      flush_words();
   endtask

   task automatic random_book();
      int r;
      r = $urandom_range(99);
      if (r < 8) book_oversubscribed(r < 4);
      else if (r < 13) book_tree(1, $urandom_range(8, 16), 1'b1);
      else book_tree(1, $urandom_range(0, 12), 1'b0);
   endtask

   task automatic settle();
      while (enc_word_q.size() != 0 || req_ch.valid || decoded_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_block_len(int v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= blen_type'(v);
      @(posedge clock);
      csr_we    <= 1'b0;
      blk_length = v;
   endtask

   task automatic run_blocks(int bl, int target);
      emit_symbols(bl, -1);
      flush_words();
      while (words_made + stream_bits.size() / WORD_BITS < target) begin
         random_book();
         put_header();
         emit_symbols(bl, -1);
         flush_words();
      end
   endtask

   // ---- Stimulus ----

   initial begin
      int k;
      int bl;
      acc_bits = '0;
      acc_count = 0;
      stage = HDR_COUNTS;
      len_idx = 1;
      foreach (len_counts[i]) len_counts[i] = 0;
      foreach (sym_len[i]) sym_len[i] = 0;
      foreach (sym_mirror[i]) sym_mirror[i] = '0;
      left_at_len = 0;
      code_next = '0;
      decoded_in_block = 0;
      blk_length = int'(BLOCK_LEN_RESET);
      words_made = 0;
      mismatch_count = 0;
      send_idle_pct = 38;
      recv_idle_pct = 50;
      req_ch.valid = 1'b0;
      req_ch.enc_word = '0;
      rsp_ch.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_block_len(1);

      // Directed blocks of one symbol each.
      book_tree(1, 0, 1'b0);
      book_sym = {0, NUM_SYMS - 1};
      put_header();
      emit_symbols(1, 1);
      book_tree(1, 15, 1'b1);
      put_header();
      emit_symbols(1, book_sym.size() - 1);
      book_oversubscribed(1'b0);
      put_header();
      emit_symbols(1, 2);
      book_oversubscribed(1'b1);
      put_header();
      emit_symbols(1, 1);
      book_tree(1, 10, 1'b0);
      put_header();
      emit_symbols(1, -1);
      random_book();
      put_header();
      flush_words();
      settle();

      write_block_len(3);
      run_blocks(3, 130);
      random_book();
      put_header();
      flush_words();
      settle();

      send_idle_pct = 50;
      recv_idle_pct = 38;
      bl = $urandom_range(4, 40);
      write_block_len(bl);
      run_blocks(bl, 300);
      // Incomplete book: one-bit and two-bit codes, the code 11 is unused.
      book_tree(1, 0, 1'b0);
      book_len = {1, 2};
      put_header();
      flush_words();
      settle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_block_len(65535);
      while (words_made + stream_bits.size() / WORD_BITS < 355) emit_symbols(1, -1);
      pad_words();
      push_bits(0, WORD_BITS);
      push_bits(0, WORD_BITS);
      flush_words();
      settle();

      // The block length drops in mid-block, so the next symbol ends it. The
      // zero bits after it that are already held open the next header.
      k = acc_count - 1;
      write_block_len(1);
      book_tree((k <= COUNT_BITS * 2 - 1) ? 3 : 6, $urandom_range(0, 10), 1'b0);
      put_header();
      repeat (k) void'(stream_bits.pop_front());
      emit_symbols(1, -1);
      flush_words();
      run_blocks(1, 400);
      // An empty book matches nothing, and the block halts.
      book_sym.delete();
      book_len.delete();
      put_header();
      repeat (4) push_bits($urandom, WORD_BITS);
      pad_words();
      enc_word_q.insert(enc_word_q.size(), word_type'('0));
      enc_word_q.insert(enc_word_q.size(), word_type'('1));

      settle();
      if (mismatch_count == 0 && decoded_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // ---- Driver ----

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) predict_word(req_ch.enc_word);
         if (!req_ch.valid || req_ch.ready) begin
            if (enc_word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid    <= 1'b1;
               req_ch.enc_word <= enc_word_q.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---- Monitor ----

   always @(posedge clock) begin
      decoded_type d;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (decoded_q.size() == 0) begin
               $error("unexpected decoded word: symbol %0h", rsp_ch.symbol);
               mismatch_count++;
            end else begin
               d = decoded_q.pop_front();
               if (rsp_ch.symbol !== d.symbol) begin
                  $error("symbol: expected %0h, got %0h", d.symbol, rsp_ch.symbol);
                  mismatch_count++;
               end
               if (rsp_ch.block_end !== d.block_end) begin
                  $error("block_end: expected %0b, got %0b", d.block_end, rsp_ch.block_end);
                  mismatch_count++;
               end
               if (rsp_ch.decode_error !== d.decode_error) begin
                  $error("decode_error: expected %0b, got %0b", d.decode_error,
                         rsp_ch.decode_error);
                  mismatch_count++;
               end
               if (rsp_ch.last !== d.last) begin
                  $error("last: expected %0b, got %0b", d.last, rsp_ch.last);
                  mismatch_count++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---- Watchdog ----

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

[files.f]
design/chb_pkg.sv
design/chb_if.sv
design/chb_ctrl.sv
design/chb_dp.sv
design/canonical_huffman_block_decoder.sv
design/chb_checker.sv
tb/tb_canonical_huffman_block_decoder.sv
